// File: rtl/core/bdq_pkg.sv
// Shared types and constants for the bounded deque with insert.
// Holds operation codes, item structs and the cell control struct.
// No dependencies.
package bdq_pkg;

  // Default number of element cells
  localparam int unsigned BDQ_CAPACITY = 64;

  // Width of one stored element
  localparam int unsigned ELEM_W = 32;

  // Operation codes carried by each input item
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } bdq_op_e;

  // Input item
  typedef struct packed {
    logic [2:0]               operation;
    logic [7:0]               position;
    logic signed [ELEM_W-1:0] value;
  } bdq_in_t;

  // Result item
  typedef struct packed {
    logic signed [ELEM_W-1:0] front_value;
    logic signed [ELEM_W-1:0] back_value;
    logic [6:0]               element_count;
    logic                     is_empty;
    logic                     dropped;
  } bdq_out_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic                     insert_en;
    logic                     pop_front;
    logic signed [ELEM_W-1:0] value;
  } bdq_ctrl_t;

endpackage

// File: rtl/core/bounded_deque_with_insert_unit.sv
// Top level of the bounded deque with positional insert.
// Depends on bdq_pkg and bdq_cell; builds the cell chain and the count control.
//
// The block holds up to CAPACITY signed 32-bit elements in a row of cells,
// slot i holding the element at position i from the front. It accepts one
// item per clock cycle while input stall is low: every operation, a positional
// insert included, is applied in one update of the cells because all cells
// shift towards their neighbours in parallel. The result item appears in the
// cycle after acceptance and sits in an output register; a new item is taken
// while the previous result is being taken, and input stall is raised only
// while a result waits under output stall. Cell contents are undefined after
// reset; only the count and the result flags are cleared.
module bounded_deque_with_insert_unit
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY = BDQ_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bdq_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bdq_out_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = (CNT_W > 8) ? CNT_W : 8;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             dropped_q, dropped_d;
  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] pos_eff;
  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    cnt_ext;
  bdq_ctrl_t        ctrl;
  logic signed [ELEM_W-1:0] cell_val [CAPACITY];
  logic signed [ELEM_W-1:0] back_val;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign pos_ext    = PW'(in_item_i.position);
  assign cnt_ext    = PW'(count_q);

  // Decode the operation into a cell command and the next count
  always_comb begin
    ctrl.insert_en = 1'b0;
    ctrl.pop_front = 1'b0;
    ctrl.value     = in_item_i.value;
    pos_eff        = count_q;
    count_d        = count_q;
    dropped_d      = 1'b0;
    if (accept) begin
      unique case (in_item_i.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            ctrl.insert_en = 1'b1;
            count_d        = count_q + CNT_W'(1);
            if (in_item_i.operation == OP_PUSH_FRONT) begin
              pos_eff = '0;
            end else if (in_item_i.operation == OP_INSERT && pos_ext < cnt_ext) begin
              pos_eff = pos_ext[CNT_W-1:0];
            end
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            ctrl.pop_front = 1'b1;
            count_d        = count_q - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Build the chain; the end cells see a zero neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ELEM_W-1:0] lower;
    logic signed [ELEM_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_val[i+1];
    end
    bdq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_eff),
      .lower_i (lower),
      .upper_i (upper),
      .value_o (cell_val[i])
    );
  end

  // Pick the back element: the cell whose index is count minus one
  always_comb begin
    back_val = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (count_q == CNT_W'(i + 1)) begin
        back_val = back_val | cell_val[i];
      end
    end
  end

  // Hold count and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= accept | (out_valid_q & out_stall_i);
      if (accept) begin
        dropped_q <= dropped_d;
      end
    end
  end

  // Result item follows the registered state
  assign out_valid_o              = out_valid_q;
  assign out_item_o.front_value   = empty ? '0 : cell_val[0];
  assign out_item_o.back_value    = back_val;
  assign out_item_o.element_count = 7'(count_q);
  assign out_item_o.is_empty      = empty;
  assign out_item_o.dropped       = dropped_q;

endmodule

// File: rtl/core/bdq_cell.sv
// One element cell of the deque chain.
// Depends on bdq_pkg for the element width and the command struct.
// Takes a new value, its lower neighbour's value or its upper neighbour's value, or holds.
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned INDEX = 0
) (
  input  logic                     clk_i,
  input  bdq_ctrl_t                ctrl_i,
  input  logic [CNT_W-1:0]         pos_i,
  input  logic signed [ELEM_W-1:0] lower_i,
  input  logic signed [ELEM_W-1:0] upper_i,
  output logic signed [ELEM_W-1:0] value_o
);

  logic signed [ELEM_W-1:0] value_q, value_d;
  logic                     at_pos;
  logic                     above_pos;

  assign at_pos    = (pos_i == CNT_W'(INDEX));
  assign above_pos = (CNT_W'(INDEX) > pos_i);

  // Select next content: shift down on pop, open a gap on insert, else hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.pop_front) begin
      value_d = upper_i;
    end else if (ctrl_i.insert_en) begin
      if (at_pos) begin
        value_d = ctrl_i.value;
      end else if (above_pos) begin
        value_d = lower_i;
      end
    end
  end

  // Payload register without reset; contents stay undefined until written
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
